// File: rtl/sprc_pkg.sv
// Shared types and constants for the sprayer pump rate controller.
// Used by sprayer_pump_rate_controller_top, the result checker and the testbench; depends on nothing else.
package sprc_pkg;

    // Operation carried by one input beat.
    typedef enum logic [1:0] {
        OP_TICK = 2'd0,
        OP_RUN  = 2'd1,
        OP_TEST = 2'd2
    } t_op;

    // Action reported with each result beat.
    typedef enum logic [1:0] {
        ACT_HOLD      = 2'd0,
        ACT_DRIVE     = 2'd1,
        ACT_FORCE_MIN = 2'd2
    } t_action;

    // Configuration register indexes.
    localparam logic [2:0] CFG_SPRAYER_ENABLE      = 3'd0;
    localparam logic [2:0] CFG_PUMP_RATE_PER_SPEED = 3'd1;
    localparam logic [2:0] CFG_SPINNER_PULSE       = 3'd2;
    localparam logic [2:0] CFG_SPEED_ON_THRESHOLD  = 3'd3;
    localparam logic [2:0] CFG_PUMP_MIN_PERCENT    = 3'd4;
    localparam logic [2:0] CFG_SPEED_MODE_ENABLE   = 3'd5;
    localparam logic [2:0] CFG_SPEED_OFF_THRESHOLD = 3'd6;
    localparam logic [2:0] CFG_UNSPRAY_DISTANCE    = 3'd7;

    // Control modes that gate switching on the waypoint distance.
    localparam logic [6:0] MODE_AUTO   = 7'd3;
    localparam logic [6:0] MODE_GUIDED = 7'd21;

    // Rate limits and scaling.
    localparam logic [18:0] RATE_MAX         = 19'd10000;
    localparam logic [15:0] UNSPRAY_LIMIT_CM = 16'd5000;
    localparam logic [6:0]  PERCENT_SCALE    = 7'd100;

    // Divide by ten as a multiply by ceil(2^23 / 10) and a shift by 23;
    // exact for dividends below 2^22.
    localparam int          DIV10_SHIFT = 23;
    localparam logic [19:0] DIV10_MUL   = 20'd838861;

endpackage

// File: rtl/sprayer_pump_rate_controller_top.sv
// Sprayer pump rate controller: decides spray on/off and the pump command.
// Depends on sprc_pkg for operation codes, action codes and constants.
//
// An accepted input beat passes through the input register, then the result
// register, to its result beat. Throughput: one beat per cycle unless stalled;
// the switching state is updated in the same cycle an item leaves the input
// register, so each item sees the state left by the one before it.
// The speed-times-rate product is formed ahead of the input register and the
// divide by ten in the second stage.
// Reset (synchronous, active low) clears both pipeline stages, the flags and
// timers, and loads the configuration registers with their default values.
module sprayer_pump_rate_controller_top #(
    parameter int unsigned TURN_ON_DELAY_MS   = 100,
    parameter int unsigned SHUT_OFF_DELAY_MS  = 1000,
    parameter int unsigned DEFAULT_UNSPRAY_CM = 500
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration write port
    input  logic        i_cfg_wr_en,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_wdata,
    // Input channel
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_operation,
    input  logic        i_request_value,
    input  logic [31:0] i_now_ms,
    input  logic [13:0] i_ground_speed_cms,
    input  logic [6:0]  i_control_mode,
    input  logic [23:0] i_waypoint_distance,
    // Result channel
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [13:0] o_pump_rate,
    output logic [1:0]  o_drive_action,
    output logic [10:0] o_spinner_pulse_out,
    output logic        o_spraying
);

    // Configuration registers.
    logic        r_sprayer_enable;
    logic [6:0]  r_pump_rate_per_speed;
    logic [10:0] r_spinner_pulse;
    logic [9:0]  r_speed_on_threshold;
    logic [6:0]  r_pump_min_percent;
    logic        r_speed_mode_enable;
    logic [9:0]  r_speed_off_threshold;
    logic [15:0] r_unspray_distance;

    // Switching state.
    logic        r_running, n_running;
    logic        r_testing, n_testing;
    logic        r_spraying, n_spraying;
    logic [31:0] r_over_start, n_over_start;
    logic [31:0] r_under_start, n_under_start;

    // Input stage.
    logic        r_in_valid;
    logic [1:0]  r_in_op;
    logic        r_in_req;
    logic [31:0] r_in_now;
    logic [13:0] r_in_speed;
    logic [20:0] r_in_prod;
    logic [6:0]  r_in_mode;
    logic [23:0] r_in_dist;

    // Result stage.
    logic        r_out_valid;
    logic [13:0] r_out_rate, n_out_rate;
    logic [1:0]  r_out_action, n_out_action;
    logic [10:0] r_out_pulse, n_out_pulse;
    logic        r_out_spraying;

    logic        out_free;
    logic        advance;
    logic        in_fire;

    logic [40:0] div_prod;
    logic [17:0] speed_term;
    logic [13:0] min_term;
    logic [18:0] rate_speed;
    logic [18:0] rate_fixed;
    logic [18:0] rate_sel;
    logic [15:0] gate_cm;
    logic        gated;
    logic        should;

    // Handshake: the result register frees when empty or taken downstream.
    assign out_free   = !r_out_valid || i_out_ready;
    assign advance    = r_in_valid && out_free;
    assign o_in_ready = !r_in_valid || advance;
    assign in_fire    = i_in_valid && o_in_ready;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sprayer_enable      <= 1'b0;
            r_pump_rate_per_speed <= 7'd10;
            r_spinner_pulse       <= 11'd1300;
            r_speed_on_threshold  <= 10'd100;
            r_pump_min_percent    <= 7'd10;
            r_speed_mode_enable   <= 1'b1;
            r_speed_off_threshold <= 10'd100;
            r_unspray_distance    <= 16'd500;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                sprc_pkg::CFG_SPRAYER_ENABLE:      r_sprayer_enable      <= i_cfg_wdata[0];
                sprc_pkg::CFG_PUMP_RATE_PER_SPEED: r_pump_rate_per_speed <= i_cfg_wdata[6:0];
                sprc_pkg::CFG_SPINNER_PULSE:       r_spinner_pulse       <= i_cfg_wdata[10:0];
                sprc_pkg::CFG_SPEED_ON_THRESHOLD:  r_speed_on_threshold  <= i_cfg_wdata[9:0];
                sprc_pkg::CFG_PUMP_MIN_PERCENT:    r_pump_min_percent    <= i_cfg_wdata[6:0];
                sprc_pkg::CFG_SPEED_MODE_ENABLE:   r_speed_mode_enable   <= i_cfg_wdata[0];
                sprc_pkg::CFG_SPEED_OFF_THRESHOLD: r_speed_off_threshold <= i_cfg_wdata[9:0];
                sprc_pkg::CFG_UNSPRAY_DISTANCE:    r_unspray_distance    <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Input register; the speed-times-rate product is captured with the beat.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_in_op    <= i_operation;
            r_in_req   <= i_request_value;
            r_in_now   <= i_now_ms;
            r_in_speed <= i_ground_speed_cms;
            r_in_prod  <= 21'(i_ground_speed_cms * r_pump_rate_per_speed);
            r_in_mode  <= i_control_mode;
            r_in_dist  <= i_waypoint_distance;
        end
    end

    // Pump rate candidates; values beyond the limit are clamped to full scale below.
    assign div_prod   = r_in_prod * sprc_pkg::DIV10_MUL;
    assign speed_term = div_prod[sprc_pkg::DIV10_SHIFT +: 18];
    assign min_term   = 14'(r_pump_min_percent * sprc_pkg::PERCENT_SCALE);
    assign rate_speed = 19'(min_term) + 19'(speed_term);
    assign rate_fixed = 19'(r_pump_rate_per_speed * sprc_pkg::PERCENT_SCALE);

    // Distance gate, falling back to the default when the setting is too large.
    assign gate_cm = (r_unspray_distance > sprc_pkg::UNSPRAY_LIMIT_CM)
                   ? 16'(DEFAULT_UNSPRAY_CM) : r_unspray_distance;
    assign gated   = (r_in_mode == sprc_pkg::MODE_AUTO)
                  || (r_in_mode == sprc_pkg::MODE_GUIDED);

    // Next state and result for the beat in the input register.
    always_comb begin
        n_running     = r_running;
        n_testing     = r_testing;
        n_spraying    = r_spraying;
        n_over_start  = r_over_start;
        n_under_start = r_under_start;
        n_out_rate    = '0;
        n_out_action  = sprc_pkg::ACT_HOLD;
        n_out_pulse   = '0;
        should        = r_spraying;
        rate_sel      = '0;

        case (sprc_pkg::t_op'(r_in_op))
            sprc_pkg::OP_RUN: begin
                if (r_in_req != r_running) begin
                    n_running = r_in_req && r_sprayer_enable;
                    if (!n_running) begin
                        n_spraying   = 1'b0;
                        n_out_action = sprc_pkg::ACT_FORCE_MIN;
                    end
                end
            end
            sprc_pkg::OP_TEST: begin
                n_testing = r_in_req;
            end
            sprc_pkg::OP_TICK: begin
                if (!r_sprayer_enable || !r_running) begin
                    // Behaves as a request to stop running.
                    if (r_running) begin
                        n_running    = 1'b0;
                        n_spraying   = 1'b0;
                        n_out_action = sprc_pkg::ACT_FORCE_MIN;
                    end
                end else begin
                    if (r_speed_mode_enable) begin
                        if (!r_spraying) begin
                            // Wait for speed held high past the turn-on delay.
                            if (r_in_speed >= 14'(r_speed_on_threshold)) begin
                                if (r_over_start == '0) begin
                                    n_over_start = r_in_now;
                                end else if ((r_in_now - r_over_start)
                                             > 32'(TURN_ON_DELAY_MS)) begin
                                    if (!gated || (r_in_dist != '0
                                                   && r_in_dist > 24'(gate_cm))) begin
                                        should       = 1'b1;
                                        n_over_start = '0;
                                    end
                                end
                            end
                            n_under_start = '0;
                        end else begin
                            // Wait for speed held low past the shut-off delay.
                            if (r_in_speed <= 14'(r_speed_off_threshold)) begin
                                if (r_under_start == '0) begin
                                    n_under_start = r_in_now;
                                end else if ((r_in_now - r_under_start)
                                             > 32'(SHUT_OFF_DELAY_MS)) begin
                                    if (!gated || (r_in_dist != '0
                                                   && r_in_dist < 24'(gate_cm))) begin
                                        should        = 1'b0;
                                        n_under_start = '0;
                                    end
                                end
                            end
                            n_over_start = '0;
                        end
                    end else begin
                        should = 1'b1;
                    end

                    if (r_testing) begin
                        should = 1'b1;
                    end

                    if (should) begin
                        if (r_testing) begin
                            rate_sel = sprc_pkg::RATE_MAX;
                        end else if (r_speed_mode_enable) begin
                            rate_sel = rate_speed;
                        end else begin
                            rate_sel = rate_fixed;
                        end
                        if (rate_sel > sprc_pkg::RATE_MAX) begin
                            rate_sel = sprc_pkg::RATE_MAX;
                        end
                        n_out_rate   = rate_sel[13:0];
                        n_out_action = sprc_pkg::ACT_DRIVE;
                        n_out_pulse  = r_spinner_pulse;
                        n_spraying   = 1'b1;
                    end else begin
                        n_out_action = sprc_pkg::ACT_FORCE_MIN;
                        n_spraying   = 1'b0;
                    end
                end
            end
            default: ;
        endcase
    end

    // State update, one beat per cycle while the result register is free.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running     <= 1'b0;
            r_testing     <= 1'b0;
            r_spraying    <= 1'b0;
            r_over_start  <= '0;
            r_under_start <= '0;
        end else if (advance) begin
            r_running     <= n_running;
            r_testing     <= n_testing;
            r_spraying    <= n_spraying;
            r_over_start  <= n_over_start;
            r_under_start <= n_under_start;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_rate     <= n_out_rate;
            r_out_action   <= n_out_action;
            r_out_pulse    <= n_out_pulse;
            r_out_spraying <= n_spraying;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_pump_rate         = r_out_rate;
    assign o_drive_action      = r_out_action;
    assign o_spinner_pulse_out = r_out_pulse;
    assign o_spraying          = r_out_spraying;

    // Spraying is only ever set while the pump is running.
    a_spray_needs_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_spraying |-> r_running)
        else $error("spraying flag set while not running");

    // A beat that does not drive the pump carries neither rate nor pulse.
    a_idle_outputs_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_drive_action != sprc_pkg::ACT_DRIVE)
        |-> (o_pump_rate == '0 && o_spinner_pulse_out == '0))
        else $error("rate or pulse present without drive action");

    // The pump command never exceeds full scale.
    a_rate_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (19'(o_pump_rate) <= sprc_pkg::RATE_MAX))
        else $error("pump rate above full scale");

    // A driving beat always reports spraying.
    a_drive_sprays: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_drive_action == sprc_pkg::ACT_DRIVE) |-> o_spraying)
        else $error("drive action without spraying");

endmodule

// File: bench/sprc_result_checker.sv
`timescale 1ns / 100ps
// Result checker for the sprayer pump rate controller bench: it watches the
// config port and both channels, predicts each result beat and compares it.
// Depends on sprc_pkg for operation, action and register codes.
module sprc_result_checker #(
    parameter int unsigned TURN_ON_DELAY_MS   = 100,
    parameter int unsigned SHUT_OFF_DELAY_MS  = 1000,
    parameter int unsigned DEFAULT_UNSPRAY_CM = 500
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_wdata,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [1:0]  i_operation,
    input  logic        i_request_value,
    input  logic [31:0] i_now_ms,
    input  logic [13:0] i_ground_speed_cms,
    input  logic [6:0]  i_control_mode,
    input  logic [23:0] i_waypoint_distance,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [13:0] i_pump_rate,
    input  logic [1:0]  i_drive_action,
    input  logic [10:0] i_spinner_pulse_out,
    input  logic        i_spraying,
    output int          o_fail_count,
    output int          o_pending
);

    localparam int unsigned SPEED_DIVISOR = 10;

    typedef struct packed {
        logic [13:0] rate;
        logic [1:0]  action;
        logic [10:0] pulse;
        logic        spraying;
    } t_pump_cmd;

    // Our copy of the configuration registers.
    logic        enable_reg;
    logic [6:0]  rate_per_speed_reg;
    logic [10:0] spinner_reg;
    logic [9:0]  on_thresh_reg;
    logic [6:0]  min_percent_reg;
    logic        speed_mode_reg;
    logic [9:0]  off_thresh_reg;
    logic [15:0] unspray_reg;

    // Our copy of the switching state.
    logic        running;
    logic        testing;
    logic        spraying;
    logic [31:0] over_since;
    logic [31:0] under_since;

    t_pump_cmd   pump_cmd_q[$];

    // A change of the running request; a drop forces the outputs to minimum.
    task automatic request_running(input logic req, output logic [1:0] act);
        act = sprc_pkg::ACT_HOLD;
        if (req != running) begin
            running = req && enable_reg;
            if (!running) begin
                spraying = 1'b0;
                act = sprc_pkg::ACT_FORCE_MIN;
            end
        end
    endtask

    // Works out the result beat of one input beat and advances the state.
    task automatic predict_pump_cmd(input logic [1:0] op, input logic req,
                                    input logic [31:0] now, input logic [13:0] speed,
                                    input logic [6:0] mode, input logic [23:0] wp_dist,
                                    output t_pump_cmd cmd);
        logic        want;
        logic        gated;
        logic [15:0] gate;
        logic [31:0] rate;
        logic [1:0]  act;
        cmd = '0;
        act = sprc_pkg::ACT_HOLD;
        case (op)
            sprc_pkg::OP_RUN: begin
                request_running(req, act);
            end
            sprc_pkg::OP_TEST: begin
                testing = req;
            end
            sprc_pkg::OP_TICK: begin
                if (!enable_reg || !running) begin
                    request_running(1'b0, act);
                end else begin
                    want  = spraying;
                    gated = (mode == sprc_pkg::MODE_AUTO) || (mode == sprc_pkg::MODE_GUIDED);
                    gate  = (unspray_reg > sprc_pkg::UNSPRAY_LIMIT_CM)
                          ? 16'(DEFAULT_UNSPRAY_CM) : unspray_reg;
                    if (speed_mode_reg) begin
                        // Switching needs the speed condition held past a delay.
                        if (!want) begin
                            if (speed >= on_thresh_reg) begin
                                if (over_since == 32'd0) begin
                                    over_since = now;
                                end else if ((now - over_since) > TURN_ON_DELAY_MS) begin
                                    if (!gated || (wp_dist != 24'd0 && wp_dist > gate)) begin
                                        want = 1'b1;
                                        over_since = 32'd0;
                                    end
                                end
                            end
                            under_since = 32'd0;
                        end else begin
                            if (speed <= off_thresh_reg) begin
                                if (under_since == 32'd0) begin
                                    under_since = now;
                                end else if ((now - under_since) > SHUT_OFF_DELAY_MS) begin
                                    if (!gated || (wp_dist != 24'd0 && wp_dist < gate)) begin
                                        want = 1'b0;
                                        under_since = 32'd0;
                                    end
                                end
                            end
                            over_since = 32'd0;
                        end
                    end else begin
                        want = running;
                    end
                    if (testing) want = 1'b1;
                    if (want) begin
                        if (testing) begin
                            rate = 32'(sprc_pkg::RATE_MAX);
                        end else if (speed_mode_reg) begin
                            rate = 32'(min_percent_reg) * 32'(sprc_pkg::PERCENT_SCALE)
                                 + (32'(speed) * 32'(rate_per_speed_reg)) / SPEED_DIVISOR;
                        end else begin
                            rate = 32'(sprc_pkg::PERCENT_SCALE) * 32'(rate_per_speed_reg);
                        end
                        // Saturating to 32767 first changes nothing after this clamp.
                        if (rate > 32'(sprc_pkg::RATE_MAX)) rate = 32'(sprc_pkg::RATE_MAX);
                        cmd.rate  = rate[13:0];
                        cmd.pulse = spinner_reg;
                        act = sprc_pkg::ACT_DRIVE;
                        spraying = 1'b1;
                    end else begin
                        act = sprc_pkg::ACT_FORCE_MIN;
                        spraying = 1'b0;
                    end
                end
            end
            default: begin
                // The unused operation leaves everything as it is.
            end
        endcase
        cmd.action   = act;
        cmd.spraying = spraying;
    endtask

    // Register writes, predictions on input beats and checks on result beats.
    always @(posedge i_clk) begin : watch
        t_pump_cmd want_cmd;
        t_pump_cmd got_cmd;
        if (!i_rst_n) begin
            enable_reg         = 1'b0;
            rate_per_speed_reg = 7'd10;
            spinner_reg        = 11'd1300;
            on_thresh_reg      = 10'd100;
            min_percent_reg    = 7'd10;
            speed_mode_reg     = 1'b1;
            off_thresh_reg     = 10'd100;
            unspray_reg        = 16'd500;
            running            = 1'b0;
            testing            = 1'b0;
            spraying           = 1'b0;
            over_since         = 32'd0;
            under_since        = 32'd0;
            pump_cmd_q.delete();
            o_fail_count       = 0;
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    sprc_pkg::CFG_SPRAYER_ENABLE:      enable_reg         = i_cfg_wdata[0];
                    sprc_pkg::CFG_PUMP_RATE_PER_SPEED: rate_per_speed_reg = i_cfg_wdata[6:0];
                    sprc_pkg::CFG_SPINNER_PULSE:       spinner_reg        = i_cfg_wdata[10:0];
                    sprc_pkg::CFG_SPEED_ON_THRESHOLD:  on_thresh_reg      = i_cfg_wdata[9:0];
                    sprc_pkg::CFG_PUMP_MIN_PERCENT:    min_percent_reg    = i_cfg_wdata[6:0];
                    sprc_pkg::CFG_SPEED_MODE_ENABLE:   speed_mode_reg     = i_cfg_wdata[0];
                    sprc_pkg::CFG_SPEED_OFF_THRESHOLD: off_thresh_reg     = i_cfg_wdata[9:0];
                    sprc_pkg::CFG_UNSPRAY_DISTANCE:    unspray_reg        = i_cfg_wdata;
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                got_cmd.rate     = i_pump_rate;
                got_cmd.action   = i_drive_action;
                got_cmd.pulse    = i_spinner_pulse_out;
                got_cmd.spraying = i_spraying;
                if (pump_cmd_q.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("%0t: result beat with none expected: rate %0d action %0d",
                                 $realtime, got_cmd.rate, got_cmd.action);
                    o_fail_count = o_fail_count + 1;
                end else begin
                    want_cmd = pump_cmd_q.pop_front();
                    if (want_cmd != got_cmd) begin
                        if (o_fail_count < 10)
                            $display({"%0t: mismatch: expected rate %0d action %0d pulse %0d",
                                      " spraying %0b, got rate %0d action %0d pulse %0d",
                                      " spraying %0b"}, $realtime,
                                     want_cmd.rate, want_cmd.action, want_cmd.pulse,
                                     want_cmd.spraying, got_cmd.rate, got_cmd.action,
                                     got_cmd.pulse, got_cmd.spraying);
                        o_fail_count = o_fail_count + 1;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                predict_pump_cmd(i_operation, i_request_value, i_now_ms, i_ground_speed_cms,
                                 i_control_mode, i_waypoint_distance, want_cmd);
                pump_cmd_q.push_back(want_cmd);
            end
        end
        o_pending = pump_cmd_q.size();
    end

endmodule

// File: bench/sprayer_pump_rate_controller_top_test.sv
`timescale 1ns / 100ps
// Testbench top for the sprayer pump rate controller: clock, reset, config
// writes, stimulus and the verdict. Depends on sprc_pkg, the block and
// sprc_result_checker.
module sprayer_pump_rate_controller_top_test;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int         ITEMS_PER_PHASE = 103;
    localparam int         NUM_PHASES = 8;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [15:0] cfg_wdata = '0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [1:0]  operation = sprc_pkg::OP_TICK;
    logic        request_value = 1'b0;
    logic [31:0] now_ms = '0;
    logic [13:0] speed_cms = '0;
    logic [6:0]  control_mode = '0;
    logic [23:0] waypoint_dist = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [13:0] rate_out;
    logic [1:0]  drive_action;
    logic [10:0] spinner_pulse_out;
    logic        spraying;
    int          fail_count;
    int          pending;

    // Idling knobs, in percent of cycles.
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;

    // What the stimulus knows of the current setting and of flight time.
    logic [9:0]  on_thresh_s;
    logic [9:0]  off_thresh_s;
    logic [15:0] gate_s;
    logic [31:0] clock_ms = 32'd0;
    logic        fast_stretch = 1'b1;

    sprayer_pump_rate_controller_top dut (
        .i_clk               (clk),
        .i_rst_n             (rst_n),
        .i_cfg_wr_en         (cfg_wr_en),
        .i_cfg_index         (cfg_index),
        .i_cfg_wdata         (cfg_wdata),
        .i_in_valid          (in_valid),
        .o_in_ready          (in_ready),
        .i_operation         (operation),
        .i_request_value     (request_value),
        .i_now_ms            (now_ms),
        .i_ground_speed_cms  (speed_cms),
        .i_control_mode      (control_mode),
        .i_waypoint_distance (waypoint_dist),
        .o_out_valid         (out_valid),
        .i_out_ready         (out_ready),
        .o_pump_rate         (rate_out),
        .o_drive_action      (drive_action),
        .o_spinner_pulse_out (spinner_pulse_out),
        .o_spraying          (spraying)
    );

    sprc_result_checker u_checker (
        .i_clk               (clk),
        .i_rst_n             (rst_n),
        .i_cfg_wr_en         (cfg_wr_en),
        .i_cfg_index         (cfg_index),
        .i_cfg_wdata         (cfg_wdata),
        .i_in_valid          (in_valid),
        .i_in_ready          (in_ready),
        .i_operation         (operation),
        .i_request_value     (request_value),
        .i_now_ms            (now_ms),
        .i_ground_speed_cms  (speed_cms),
        .i_control_mode      (control_mode),
        .i_waypoint_distance (waypoint_dist),
        .i_out_valid         (out_valid),
        .i_out_ready         (out_ready),
        .i_pump_rate         (rate_out),
        .i_drive_action      (drive_action),
        .i_spinner_pulse_out (spinner_pulse_out),
        .i_spraying          (spraying),
        .o_fail_count        (fail_count),
        .o_pending           (pending)
    );

    // 50 MHz clock.
    initial begin
        forever #10 clk = ~clk;
    end

    // The receiver stalls at random at the rate of the current phase.
    always @(posedge clk) begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Hard stop in case the block hangs.
    initial begin
        #10_000_000;
        $display("tb: failure");
        $finish;
    end

    // Sends one beat, after a random idle gap, and waits until it is taken.
    task automatic send_beat(input logic [1:0] op, input logic req, input logic [31:0] now,
                             input logic [13:0] speed, input logic [6:0] mode,
                             input logic [23:0] wp_dist);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid      <= 1'b1;
        operation     <= op;
        request_value <= req;
        now_ms        <= now;
        speed_cms     <= speed;
        control_mode  <= mode;
        waypoint_dist <= wp_dist;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    // Holds the sender back until every expected result beat has come.
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // One register write; the enable is high for a single cycle and then drops.
    task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
    endtask

    // Programs every register for one phase: extremes on some, random on the rest.
    task automatic configure_phase(input int phase);
        logic        en;
        logic [6:0]  rps;
        logic [10:0] pulse;
        logic [9:0]  on_t;
        logic [6:0]  min_p;
        logic        smode;
        logic [9:0]  off_t;
        logic [15:0] unspray;
        en      = ($urandom_range(9) != 0);
        rps     = 7'($urandom_range(127));
        pulse   = 11'($urandom_range(2047));
        on_t    = 10'($urandom_range(1023));
        min_p   = 7'($urandom_range(127));
        smode   = ($urandom_range(4) != 0);
        off_t   = 10'($urandom_range(1023));
        unspray = $urandom_range(1) ? 16'($urandom_range(6000)) : 16'($urandom);
        case (phase)
            1: begin
                en = 1'b1; rps = 7'd0; pulse = 11'd1000; on_t = 10'd0;
                min_p = 7'd0; smode = 1'b1; off_t = 10'd0; unspray = 16'd0;
            end
            2: begin
                en = 1'b1; rps = 7'd100; pulse = 11'd2000; on_t = 10'd1000;
                min_p = 7'd100; smode = 1'b1; off_t = 10'd1000; unspray = 16'hFFFF;
            end
            3: begin
                en = 1'b1; rps = 7'd127; pulse = 11'd2047; on_t = 10'd1023;
                min_p = 7'd127; off_t = 10'd1023; unspray = 16'd5000;
            end
            5: begin
                en = 1'b1; smode = 1'b0;
            end
            6: begin
                en = 1'b0;
            end
            default: begin
                en = 1'b1;
            end
        endcase
        write_reg(sprc_pkg::CFG_SPRAYER_ENABLE, 16'(en));
        write_reg(sprc_pkg::CFG_PUMP_RATE_PER_SPEED, 16'(rps));
        write_reg(sprc_pkg::CFG_SPINNER_PULSE, 16'(pulse));
        write_reg(sprc_pkg::CFG_SPEED_ON_THRESHOLD, 16'(on_t));
        write_reg(sprc_pkg::CFG_PUMP_MIN_PERCENT, 16'(min_p));
        write_reg(sprc_pkg::CFG_SPEED_MODE_ENABLE, 16'(smode));
        write_reg(sprc_pkg::CFG_SPEED_OFF_THRESHOLD, 16'(off_t));
        write_reg(sprc_pkg::CFG_UNSPRAY_DISTANCE, unspray);
        on_thresh_s  = on_t;
        off_thresh_s = off_t;
        gate_s       = (unspray > sprc_pkg::UNSPRAY_LIMIT_CM) ? 16'd500 : unspray;
    endtask

    // One random beat: mostly update ticks along a plausible flight, with
    // speed held above or below the thresholds for stretches of time.
    task automatic send_random_beat();
        int          roll;
        logic [1:0]  op;
        logic        req;
        logic [13:0] speed;
        logic [6:0]  mode;
        logic [23:0] wp_dist;
        logic [31:0] top_speed;
        roll    = $urandom_range(99);
        req     = 1'($urandom_range(1));
        speed   = 14'($urandom);
        mode    = 7'($urandom);
        wp_dist = 24'($urandom);
        if (roll < 4) begin
            op  = sprc_pkg::OP_RUN;
            req = ($urandom_range(4) != 0);
        end else if (roll < 9) begin
            op  = sprc_pkg::OP_TEST;
            req = ($urandom_range(3) == 0);
        end else if (roll < 11) begin
            op  = OP_UNUSED;
        end else begin
            op = sprc_pkg::OP_TICK;
            // Flight time mostly moves forward a little, now and then jumps.
            roll = $urandom_range(99);
            if (roll < 3) clock_ms = $urandom;
            else if (roll < 5) clock_ms = 32'd0;
            else clock_ms = clock_ms + 32'($urandom_range(1, 250));
            if ($urandom_range(99) < 8) fast_stretch = ~fast_stretch;
            if ($urandom_range(9) != 0) begin
                if (fast_stretch) begin
                    top_speed = 32'(on_thresh_s) + 32'd400;
                    speed = 14'($urandom_range(on_thresh_s, top_speed));
                end else begin
                    speed = 14'($urandom_range(off_thresh_s));
                end
            end
            if ($urandom_range(99) < 45)
                mode = $urandom_range(1) ? sprc_pkg::MODE_AUTO : sprc_pkg::MODE_GUIDED;
            roll = $urandom_range(99);
            if (roll < 15) wp_dist = 24'd0;
            else if (roll < 60) wp_dist = 24'($urandom_range(32'(gate_s) * 2 + 2));
        end
        send_beat(op, req, clock_ms, speed, mode, wp_dist);
    endtask

    // Main sequence.
    initial begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: the block is still disabled after reset.
        send_beat(sprc_pkg::OP_TICK, 1'b0, 32'd5, 14'd500, 7'd0, 24'd1000);
        send_beat(sprc_pkg::OP_RUN, 1'b1, 32'd0, 14'd0, 7'd0, 24'd0);
        send_beat(OP_UNUSED, 1'b1, 32'hFFFF_FFFF, 14'h3FFF, 7'h7F, 24'hFF_FFFF);
        send_beat(sprc_pkg::OP_TEST, 1'b1, 32'd0, 14'd0, 7'd0, 24'd0);
        send_beat(sprc_pkg::OP_TEST, 1'b0, 32'd0, 14'd0, 7'd0, 24'd0);
        drain_results();
        write_reg(sprc_pkg::CFG_SPRAYER_ENABLE, 16'd1);

        // Directed: start, switch on through the delay, off again, testing.
        send_beat(sprc_pkg::OP_RUN, 1'b1, 32'd0, 14'd0, 7'd0, 24'd0);
        send_beat(sprc_pkg::OP_RUN, 1'b1, 32'd0, 14'd0, 7'd0, 24'd0);
        // A timer started at time zero reads as not started.
        send_beat(sprc_pkg::OP_TICK, 1'b0, 32'd0, 14'h3FFF, 7'd0, 24'd0);
        send_beat(sprc_pkg::OP_TICK, 1'b0, 32'd50, 14'h3FFF, 7'd0, 24'd0);
        // Distance gating with an unknown distance holds the switch.
        send_beat(sprc_pkg::OP_TICK, 1'b0, 32'd200, 14'h3FFF, sprc_pkg::MODE_AUTO, 24'd0);
        // On, with a rate that overflows past full scale.
        send_beat(sprc_pkg::OP_TICK, 1'b0, 32'd300, 14'h3FFF, sprc_pkg::MODE_GUIDED,
                  24'hFF_FFFF);
        send_beat(sprc_pkg::OP_TICK, 1'b0, 32'd400, 14'd0, 7'd0, 24'd0);
        send_beat(sprc_pkg::OP_TICK, 1'b0, 32'd2000, 14'd0, sprc_pkg::MODE_AUTO, 24'd600);
        send_beat(sprc_pkg::OP_TICK, 1'b0, 32'd2100, 14'd0, 7'd0, 24'd0);
        send_beat(sprc_pkg::OP_TEST, 1'b1, 32'd0, 14'd0, 7'd0, 24'd0);
        send_beat(sprc_pkg::OP_TICK, 1'b0, 32'd2200, 14'd0, 7'h7F, 24'd1);
        send_beat(sprc_pkg::OP_TEST, 1'b0, 32'd0, 14'd0, 7'd0, 24'd0);
        // Timers across the wrap of the millisecond counter.
        send_beat(sprc_pkg::OP_TICK, 1'b0, 32'hFFFF_FFA0, 14'd150, 7'd0, 24'd0);
        send_beat(sprc_pkg::OP_TICK, 1'b0, 32'h0000_0010, 14'd150, 7'd0, 24'd0);
        send_beat(sprc_pkg::OP_RUN, 1'b0, 32'd0, 14'd0, 7'd0, 24'd0);
        send_beat(sprc_pkg::OP_TICK, 1'b1, 32'd3000, 14'd200, 7'd0, 24'd0);
        drain_results();
        write_reg(sprc_pkg::CFG_SPEED_MODE_ENABLE, 16'd0);
        send_beat(sprc_pkg::OP_RUN, 1'b1, 32'd0, 14'd0, 7'd0, 24'd0);
        send_beat(sprc_pkg::OP_TICK, 1'b0, 32'd3100, 14'd0, 7'd0, 24'd0);

        // Random phases, each with its own setting and idling pattern.
        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            drain_results();
            configure_phase(phase);
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct <= 0;  end
                1: begin send_idle_pct = 86; recv_stall_pct <= 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct <= 86; end
                default: begin send_idle_pct = 15; recv_stall_pct <= 15; end
            endcase
            clock_ms = 32'($urandom_range(1, 100000));
            send_beat(sprc_pkg::OP_RUN, 1'b1, clock_ms, 14'd0, 7'd0, 24'd0);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) send_random_beat();
        end

        drain_results();
        repeat (10) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// File: sprayer_pump_rate_controller_top.f
rtl/sprc_pkg.sv
rtl/sprayer_pump_rate_controller_top.sv
bench/sprc_result_checker.sv
bench/sprayer_pump_rate_controller_top_test.sv
